FILE: hdl/v3a_pkg.sv
// ============================================================================
// v3a_pkg - shared types and constants for the vector arithmetic unit
// Operation codes, lane/result structs and fixed field widths.
// ============================================================================
package v3a_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VEC_W         = 32;
  localparam int SCL_W         = 64;
  localparam int LANES         = 3;
  localparam int DIV_STEPS     = 32;

  typedef enum logic [2:0] {
    OP_MAG   = 3'd0,
    OP_SCALE = 3'd1,
    OP_ADD   = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_PROJ  = 3'd5,
    OP_AREA  = 3'd6
  } op_t;

  // per-lane vector answers after clipping
  typedef struct packed {
    logic [VEC_W-1:0] scl;
    logic [VEC_W-1:0] add;
    logic [VEC_W-1:0] crs;
    logic             scl_sat;
    logic             add_sat;
    logic             crs_sat;
  } lane_vec_t;

  // sideband that travels along the pipeline
  typedef struct packed {
    op_t                        kind;
    logic [LANES-1:0][VEC_W-1:0] vec;
    logic                       sat;
    logic [SCL_W-1:0]           scal;
    logic                       zd;
  } meta_t;

  typedef struct packed {
    logic [VEC_W-1:0] res_x;
    logic [VEC_W-1:0] res_y;
    logic [VEC_W-1:0] res_z;
    logic [SCL_W-1:0] res_scalar;
    logic             is_scalar;
    logic             saturated;
    logic             zero_divisor;
  } rsp_t;

endpackage

FILE: hdl/v3a_in_if.sv
// ============================================================================
// v3a_in_if - request channel of the vector arithmetic unit
// valid/ready handshake with operation code, two vectors and a factor.
// ============================================================================
interface v3a_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] u_x;
  logic signed [31:0] u_y;
  logic signed [31:0] u_z;
  logic signed [31:0] v_x;
  logic signed [31:0] v_y;
  logic signed [31:0] v_z;
  logic signed [15:0] scale_factor;

  modport source (output valid, kind, u_x, u_y, u_z, v_x, v_y, v_z, scale_factor,
                  input ready);
  modport sink   (input valid, kind, u_x, u_y, u_z, v_x, v_y, v_z, scale_factor,
                  output ready);
endinterface

FILE: hdl/v3a_out_if.sv
// ============================================================================
// v3a_out_if - result channel of the vector arithmetic unit
// valid/ready handshake with vector, scalar and flag fields.
// ============================================================================
interface v3a_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;
  logic signed [31:0] res_z;
  logic signed [63:0] res_scalar;
  logic               is_scalar;
  logic               saturated;
  logic               zero_divisor;

  modport source (output valid, res_x, res_y, res_z, res_scalar, is_scalar, saturated,
                  zero_divisor, input ready);
  modport sink   (input valid, res_x, res_y, res_z, res_scalar, is_scalar, saturated,
                  zero_divisor, output ready);
endinterface

FILE: hdl/v3a_lane.sv
// ============================================================================
// v3a_lane - one vector component lane
// Products, clipping, projection multiply and a 32-step pipelined divider.
// ============================================================================
module v3a_lane
  import v3a_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               adv,
  input  logic signed [31:0] u_i,
  input  logic signed [31:0] v_i,
  input  logic signed [31:0] u_j,
  input  logic signed [31:0] v_j,
  input  logic signed [31:0] u_k,
  input  logic signed [31:0] v_k,
  input  logic signed [15:0] sf,
  output logic [63:0]        sq_u,
  output logic [63:0]        sq_v,
  output logic signed [63:0] dot_p,
  output lane_vec_t          vec,
  output logic [63:0]        sqw,
  input  logic [63:0]        dm,
  input  logic               dneg,
  input  logic [63:0]        nn,
  output logic [31:0]        proj,
  output logic               proj_sat
);

  localparam int ROOT_W = VEC_W + FRAC_BITS;
  localparam int DLY    = ROOT_W - DIV_STEPS - 1;

  // {sat, value}
  function automatic logic [32:0] clip32(input logic signed [64:0] v);
    logic hi, lo;
    hi = !v[64] && (|v[63:31]);
    lo = v[64] && !(&v[63:31]);
    if (hi) begin
      clip32 = {1'b1, 32'h7fff_ffff};
    end else if (lo) begin
      clip32 = {1'b1, 32'h8000_0000};
    end else begin
      clip32 = {1'b0, v[31:0]};
    end
  endfunction

  // stage 1: products
  logic signed [63:0] m_uu, m_vv, m_uv, m_ca, m_cb;
  logic signed [47:0] m_scl;
  logic signed [32:0] s_add;
  assign m_uu  = u_i * u_i;
  assign m_vv  = v_i * v_i;
  assign m_uv  = u_i * v_i;
  assign m_ca  = u_j * v_k;
  assign m_cb  = u_k * v_j;
  assign m_scl = u_i * sf;
  assign s_add = u_i + v_i;

  logic signed [63:0] ca_r, cb_r;
  logic signed [47:0] scl_r;
  logic signed [32:0] add_r;
  logic [31:0]        va1_r, va2_r, va3_r;
  logic               vn1_r, vn2_r, vn3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_u  <= m_uu;
      sq_v  <= m_vv;
      dot_p <= m_uv;
      ca_r  <= m_ca;
      cb_r  <= m_cb;
      scl_r <= m_scl;
      add_r <= s_add;
      va1_r <= v_i[31] ? (~v_i + 32'd1) : v_i;
      vn1_r <= v_i[31];
    end
  end

  // stage 2: cross difference with floor shift, clip everything
  logic signed [64:0] dcx, dcx_sh;
  logic [32:0]        c_crs, c_scl, c_add;
  assign dcx    = ca_r - cb_r;
  assign dcx_sh = dcx >>> FRAC_BITS;
  assign c_crs  = clip32(dcx_sh);
  assign c_scl  = clip32(65'(scl_r));
  assign c_add  = clip32(65'(add_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      vec.crs     <= c_crs[31:0];
      vec.crs_sat <= c_crs[32];
      vec.scl     <= c_scl[31:0];
      vec.scl_sat <= c_scl[32];
      vec.add     <= c_add[31:0];
      vec.add_sat <= c_add[32];
      va2_r       <= va1_r;
      vn2_r       <= vn1_r;
    end
  end

  // stage 3: square of the clipped cross component (area)
  logic signed [31:0] crs_s;
  logic signed [63:0] m_ww;
  assign crs_s = vec.crs;
  assign m_ww  = crs_s * crs_s;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqw   <= m_ww;
      va3_r <= va2_r;
      vn3_r <= vn2_r;
    end
  end

  // stage 4/5: |v| * |u.v| as two 32x32 partial products
  logic [63:0] pl_r, ph_r;
  logic        ng4_r, ng5_r;
  logic [95:0] p5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r  <= va3_r * dm[31:0];
      ph_r  <= va3_r * dm[63:32];
      ng4_r <= dneg ^ vn3_r;
      p5_r  <= {32'd0, pl_r} + {ph_r, 32'd0};
      ng5_r <= ng4_r;
    end
  end

  // stage 6: quotient >= 2^32 check, then one quotient bit per stage
  logic [63:0] dv_rem_r [0:DIV_STEPS-1];
  logic [63:0] dv_nn_r  [0:DIV_STEPS-1];
  logic [31:0] dv_low_r [0:DIV_STEPS];
  logic        dv_big_r [0:DIV_STEPS];
  logic        dv_neg_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0] <= p5_r[95:32];
      dv_low_r[0] <= p5_r[31:0];
      dv_nn_r[0]  <= nn;
      dv_big_r[0] <= p5_r[95:32] >= nn;
      dv_neg_r[0] <= ng5_r;
    end
  end

  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [64:0] t;
    logic        ge;
    assign t  = {dv_rem_r[j-1], dv_low_r[j-1][31]};
    assign ge = t >= {1'b0, dv_nn_r[j-1]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_low_r[j] <= {dv_low_r[j-1][30:0], ge};
        dv_big_r[j] <= dv_big_r[j-1];
        dv_neg_r[j] <= dv_neg_r[j-1];
      end
    end
    if (j < DIV_STEPS) begin : g_carry
      logic [64:0] diff;
      assign diff = t - {1'b0, dv_nn_r[j-1]};
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem_r[j] <= ge ? diff[63:0] : t[63:0];
          dv_nn_r[j]  <= dv_nn_r[j-1];
        end
      end
    end
  end

  // align with the root pipeline
  logic [31:0] dq_r   [1:DLY];
  logic        dbig_r [1:DLY];
  logic        dneg_r [1:DLY];

  always_ff @(posedge clk) begin
    if (adv) begin
      dq_r[1]   <= dv_low_r[DIV_STEPS];
      dbig_r[1] <= dv_big_r[DIV_STEPS];
      dneg_r[1] <= dv_neg_r[DIV_STEPS];
    end
  end

  for (genvar d = 2; d <= DLY; d++) begin : g_dly
    always_ff @(posedge clk) begin
      if (adv) begin
        dq_r[d]   <= dq_r[d-1];
        dbig_r[d] <= dbig_r[d-1];
        dneg_r[d] <= dneg_r[d-1];
      end
    end
  end

  logic [31:0] q;
  logic        qn, over;
  assign q    = dq_r[DLY];
  assign qn   = dneg_r[DLY];
  assign over = dbig_r[DLY] | (q[31] & (!qn | (|q[30:0])));

  always_comb begin
    if (over) begin
      proj = qn ? 32'h8000_0000 : 32'h7fff_ffff;
    end else if (qn) begin
      proj = ~q + 32'd1;
    end else begin
      proj = q;
    end
  end
  assign proj_sat = over;

endmodule

FILE: hdl/v3a_sqrt.sv
// ============================================================================
// v3a_sqrt - pipelined floor square root
// One result bit per stage of (rad << 2*FRAC_BITS).
// ============================================================================
module v3a_sqrt
  import v3a_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [63:0]                rad,
  output logic [VEC_W+FRAC_BITS-1:0] root
);

  localparam int ROOT_W = VEC_W + FRAC_BITS;
  localparam int XW     = 2 * ROOT_W;

  logic [XW-1:0]     x_r    [1:ROOT_W-1];
  logic [ROOT_W+1:0] rem_r  [1:ROOT_W-1];
  logic [ROOT_W-1:0] root_r [1:ROOT_W];

  for (genvar s = 1; s <= ROOT_W; s++) begin : g_st
    logic [XW-1:0]     x_in;
    logic [ROOT_W+1:0] rem_in, cur, trial;
    logic [ROOT_W-1:0] root_in;
    logic              ge;

    if (s == 1) begin : g_first
      assign x_in    = {rad, {(2*FRAC_BITS){1'b0}}};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign root_in = root_r[s-1];
    end

    assign cur   = {rem_in[ROOT_W-1:0], x_in[XW-1 -: 2]};
    assign trial = {root_in, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[s] <= {root_in[ROOT_W-2:0], ge};
      end
    end

    if (s < ROOT_W) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          x_r[s]   <= x_in << 2;
          rem_r[s] <= ge ? (cur - trial) : cur;
        end
      end
    end
  end

  assign root = root_r[ROOT_W];

endmodule

FILE: hdl/vector3_arith_unit.sv
// ============================================================================
// vector3_arith_unit - three-component vector ALU, signed fixed point
// Magnitude, scale, add, dot, cross, projection and area in one pipeline.
// ============================================================================
//
//  channel   | dir | handshake       | content
//  ----------+-----+-----------------+------------------------------------------
//  in_req    | in  | valid / ready   | kind, u_x..u_z, v_x..v_z, scale_factor
//  out_rsp   | out | valid / ready   | res_x..res_z, res_scalar, flags
//
//  One request per cycle sustained while the output side keeps up; a stall at
//  the output holds the whole pipe. A request's result shows on out_rsp once
//  it has passed every stage; the depth is set by the root pipeline, one result
//  bit per stage over 32 + FRAC_BITS bits (48 at Q16.16).
//  Reset is synchronous, active low; it clears the stage valid bits and the
//  output valid bit only. No request is taken while reset is held.
//  A stalled result sits in the output register; the pipe keeps accepting
//  until a finished request reaches the last stage with nowhere to go.
//
module vector3_arith_unit
  import v3a_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  v3a_in_if.sink    in_req,
  v3a_out_if.source out_rsp
);

  localparam int ROOT_W = VEC_W + FRAC_BITS;
  localparam int NST    = ROOT_W + 5;   // last pipeline stage

  // pipeline advance: blocked only when the last stage and output both hold
  logic           adv;
  logic [NST:1]   vld_r;
  logic           out_vld_r;
  rsp_t           out_r, out_nxt;

  // sideband line: kind, early answers and flags ride along to the end
  meta_t meta_r [1:NST];

  assign adv          = !(vld_r[NST] && out_vld_r && !out_rsp.ready);
  assign in_req.ready = adv && rst_n;

  // ---------------------------------------------------------------------------
  // lanes: one per vector component
  // ---------------------------------------------------------------------------
  logic signed [31:0] u [LANES];
  logic signed [31:0] v [LANES];
  assign u[0] = in_req.u_x;
  assign u[1] = in_req.u_y;
  assign u[2] = in_req.u_z;
  assign v[0] = in_req.v_x;
  assign v[1] = in_req.v_y;
  assign v[2] = in_req.v_z;

  logic [63:0]        l_squ  [LANES];
  logic [63:0]        l_sqv  [LANES];
  logic signed [63:0] l_dot  [LANES];
  lane_vec_t          l_vec  [LANES];
  logic [63:0]        l_sqw  [LANES];
  logic [31:0]        l_proj [LANES];
  logic               l_psat [LANES];

  // shared merge registers
  logic [63:0]        squ2_r, sqv2_r, squ3_r, squ4_r;
  logic signed [65:0] dot2_r;
  logic [63:0]        dm3_r, nn3_r, nn4_r, nn5_r, sqw4_r, rad5_r;
  logic               dneg3_r;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    v3a_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk      (clk),
      .adv      (adv),
      .u_i      (u[i]),
      .v_i      (v[i]),
      .u_j      (u[(i+1)%LANES]),
      .v_j      (v[(i+1)%LANES]),
      .u_k      (u[(i+2)%LANES]),
      .v_k      (v[(i+2)%LANES]),
      .sf       (in_req.scale_factor),
      .sq_u     (l_squ[i]),
      .sq_v     (l_sqv[i]),
      .dot_p    (l_dot[i]),
      .vec      (l_vec[i]),
      .sqw      (l_sqw[i]),
      .dm       (dm3_r),
      .dneg     (dneg3_r),
      .nn       (nn5_r),
      .proj     (l_proj[i]),
      .proj_sat (l_psat[i])
    );
  end

  // ---------------------------------------------------------------------------
  // merge stages: sums across lanes, dot clip, divisor and radicand
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 2
      squ2_r  <= l_squ[0] + l_squ[1] + l_squ[2];
      sqv2_r  <= l_sqv[0] + l_sqv[1] + l_sqv[2];
      dot2_r  <= 66'(l_dot[0]) + 66'(l_dot[1]) + 66'(l_dot[2]);
      // stage 3: |u.v| feeds the projection multipliers
      squ3_r  <= squ2_r;
      nn3_r   <= sqv2_r;
      dm3_r   <= dot2_r[65] ? 64'(-dot2_r) : dot2_r[63:0];
      dneg3_r <= dot2_r[65];
      // stage 4
      sqw4_r  <= l_sqw[0] + l_sqw[1] + l_sqw[2];
      squ4_r  <= squ3_r;
      nn4_r   <= nn3_r;
      // stage 5: radicand is |u|^2 or |u x v|^2
      rad5_r  <= (meta_r[4].kind == OP_AREA) ? sqw4_r : squ4_r;
      nn5_r   <= nn4_r;
    end
  end

  logic [ROOT_W-1:0] root;

  v3a_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk  (clk),
    .adv  (adv),
    .rad  (rad5_r),
    .root (root)
  );

  // ---------------------------------------------------------------------------
  // sideband stages
  // ---------------------------------------------------------------------------
  logic        dot_ovf;
  logic [63:0] dot_clip;
  assign dot_ovf  = (dot2_r[65:63] != 3'b000) && (dot2_r[65:63] != 3'b111);
  assign dot_clip = dot_ovf ? (dot2_r[65] ? 64'h8000_0000_0000_0000
                                          : 64'h7fff_ffff_ffff_ffff)
                            : dot2_r[63:0];

  for (genvar k = 1; k <= NST; k++) begin : g_meta
    meta_t nxt;
    if (k == 1) begin : g_in
      always_comb begin
        nxt      = '0;
        nxt.kind = op_t'(in_req.kind);
      end
    end else if (k == 3) begin : g_early
      // vector answers and dot land here
      always_comb begin
        nxt = meta_r[k-1];
        case (meta_r[k-1].kind)
          OP_SCALE: begin
            for (int n = 0; n < LANES; n++) nxt.vec[n] = l_vec[n].scl;
            nxt.sat = l_vec[0].scl_sat | l_vec[1].scl_sat | l_vec[2].scl_sat;
          end
          OP_ADD: begin
            for (int n = 0; n < LANES; n++) nxt.vec[n] = l_vec[n].add;
            nxt.sat = l_vec[0].add_sat | l_vec[1].add_sat | l_vec[2].add_sat;
          end
          OP_CROSS: begin
            for (int n = 0; n < LANES; n++) nxt.vec[n] = l_vec[n].crs;
            nxt.sat = l_vec[0].crs_sat | l_vec[1].crs_sat | l_vec[2].crs_sat;
          end
          OP_AREA: begin
            nxt.sat = l_vec[0].crs_sat | l_vec[1].crs_sat | l_vec[2].crs_sat;
          end
          OP_DOT: begin
            nxt.scal = dot_clip;
            nxt.sat  = dot_ovf;
          end
          OP_PROJ: begin
            nxt.zd = (sqv2_r == 64'd0);
          end
          default: begin
          end
        endcase
      end
    end else begin : g_pass
      assign nxt = meta_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        meta_r[k] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-1:1], in_req.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // final select into the output register
  // ---------------------------------------------------------------------------
  meta_t mf;
  assign mf = meta_r[NST];

  always_comb begin
    out_nxt = '0;
    case (mf.kind)
      OP_MAG, OP_AREA: begin
        out_nxt.res_scalar = 64'(root);
        out_nxt.is_scalar  = 1'b1;
        out_nxt.saturated  = mf.sat;
      end
      OP_DOT: begin
        out_nxt.res_scalar = mf.scal;
        out_nxt.is_scalar  = 1'b1;
        out_nxt.saturated  = mf.sat;
      end
      OP_SCALE, OP_ADD, OP_CROSS: begin
        out_nxt.res_x     = mf.vec[0];
        out_nxt.res_y     = mf.vec[1];
        out_nxt.res_z     = mf.vec[2];
        out_nxt.saturated = mf.sat;
      end
      OP_PROJ: begin
        if (mf.zd) begin
          out_nxt.zero_divisor = 1'b1;
        end else begin
          out_nxt.res_x     = l_proj[0];
          out_nxt.res_y     = l_proj[1];
          out_nxt.res_z     = l_proj[2];
          out_nxt.saturated = l_psat[0] | l_psat[1] | l_psat[2];
        end
      end
      default: begin
      end
    endcase
  end

  logic load;
  assign load = vld_r[NST] && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load) begin
      out_vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_rsp.valid        = out_vld_r;
  assign out_rsp.res_x        = out_r.res_x;
  assign out_rsp.res_y        = out_r.res_y;
  assign out_rsp.res_z        = out_r.res_z;
  assign out_rsp.res_scalar   = out_r.res_scalar;
  assign out_rsp.is_scalar    = out_r.is_scalar;
  assign out_rsp.saturated    = out_r.saturated;
  assign out_rsp.zero_divisor = out_r.zero_divisor;

endmodule

FILE: hdl/v3a_checker.sv
// ============================================================================
// v3a_checker - port-level checks for the vector arithmetic unit
// Result consistency and output hold, bound onto the top level.
// ============================================================================
module v3a_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] res_x,
  input logic [31:0] res_y,
  input logic [31:0] res_z,
  input logic [63:0] res_scalar,
  input logic        is_scalar,
  input logic        saturated,
  input logic        zero_divisor
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(res_x) && $stable(res_scalar)
      && $stable(is_scalar))
    else $error("stalled result changed");

  // a vector answer leaves the scalar field clear
  a_vec_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_scalar |-> res_scalar == 64'd0)
    else $error("scalar field set on vector result");

  // a scalar answer leaves the vector fields clear
  a_scl_clr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_scalar |-> res_x == 32'd0 && res_y == 32'd0 && res_z == 32'd0)
    else $error("vector field set on scalar result");

  // zero divisor: vector fields, saturated and is_scalar are all clear
  a_zdiv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && zero_divisor |-> !saturated && !is_scalar && res_x == 32'd0
      && res_y == 32'd0 && res_z == 32'd0)
    else $error("zero divisor result not clear");

  // no result right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vector3_arith_unit v3a_checker u_v3a_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .res_x        (out_rsp.res_x),
  .res_y        (out_rsp.res_y),
  .res_z        (out_rsp.res_z),
  .res_scalar   (out_rsp.res_scalar),
  .is_scalar    (out_rsp.is_scalar),
  .saturated    (out_rsp.saturated),
  .zero_divisor (out_rsp.zero_divisor)
);

FILE: verif/tb_vector3_arith_unit.sv
// ============================================================================
// tb_vector3_arith_unit - self-checking bench for the vector arithmetic unit
// Requests come from a queue that is filled up front. Each accepted request
// is predicted in exact wide arithmetic, and every result is checked in order.
// Both sides stall in random bursts, and once the result side holds off long
// enough to fill the pipe.
// ============================================================================
module tb_vector3_arith_unit;
  import v3a_pkg::*;

  localparam int FRAC      = FRAC_BITS_DEF;
  localparam int N_RANDOM  = 1500;
  localparam int QUIET_TAIL = 150;
  localparam int HOLD_LEN  = 300;

  typedef struct {
    logic [2:0]         kind;
    logic signed [31:0] u [3];
    logic signed [31:0] v [3];
    logic signed [15:0] sf;
  } vec_req_t;

  logic clk;
  logic rst_n;
  v3a_in_if  in_ch();
  v3a_out_if out_ch();

  vector3_arith_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_rsp(out_ch)
  );

  vec_req_t pending_reqs[$];
  rsp_t     expected_rsps[$];
  int       n_errors;
  int       n_results;
  bit       stim_done;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [31:0] clip32(input logic signed [127:0] val,
                                                 inout logic flag);
    if (val > 128'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (val < -128'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return val[31:0];
  endfunction

  function automatic logic [63:0] sum_squares(input logic signed [31:0] c [3]);
    logic [63:0] acc;
    logic [63:0] a;
    acc = '0;
    for (int n = 0; n < 3; n++) begin
      a = (c[n] < 0) ? 64'(-64'sd1 * c[n]) : 64'(c[n]);
      acc += a * a;
    end
    return acc;
  endfunction

  // floor square root of the sum of squares scaled up to the scalar format
  function automatic logic [63:0] length_of(input logic signed [31:0] c [3]);
    logic [127:0] x;
    logic [127:0] sq;
    logic [63:0]  r;
    logic [63:0]  t;
    x = {64'd0, sum_squares(c)} << (2 * FRAC);
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t  = r | (64'd1 << b);
      sq = {64'd0, t};
      sq = sq * sq;
      if (sq <= x) r = t;
    end
    return r;
  endfunction

  function automatic void cross_of(input logic signed [31:0] a [3],
                                   input logic signed [31:0] b [3],
                                   output logic signed [31:0] w [3],
                                   inout logic flag);
    logic signed [127:0] t [3];
    logic signed [127:0] p;
    t[0] = a[1] * b[2];  p = a[2];  p = p * b[1];  t[0] = t[0] - p;
    t[1] = a[2] * b[0];  p = a[0];  p = p * b[2];  t[1] = t[1] - p;
    t[2] = a[0] * b[1];  p = a[1];  p = p * b[0];  t[2] = t[2] - p;
    for (int n = 0; n < 3; n++) w[n] = clip32(t[n] >>> FRAC, flag);
  endfunction

  function automatic logic signed [127:0] dot_of(input logic signed [31:0] a [3],
                                                 input logic signed [31:0] b [3]);
    logic signed [127:0] d;
    logic signed [127:0] p;
    d = '0;
    for (int n = 0; n < 3; n++) begin
      p = a[n];
      p = p * b[n];
      d = d + p;
    end
    return d;
  endfunction

  function automatic rsp_t predict_vec_op(input vec_req_t rq);
    rsp_t                r;
    logic signed [31:0]  w [3];
    logic signed [127:0] d;
    logic signed [127:0] p;
    logic [127:0]        dm;
    logic [127:0]        q;
    logic [63:0]         nn;
    logic [63:0]         av;
    logic                sat;
    logic                neg;
    r   = '0;
    sat = 1'b0;
    w   = '{default: '0};
    case (rq.kind)
      OP_MAG: begin
        r.res_scalar = length_of(rq.u);
        r.is_scalar  = 1'b1;
      end
      OP_SCALE: begin
        for (int n = 0; n < 3; n++) begin
          p = rq.u[n];
          p = p * rq.sf;
          w[n] = clip32(p, sat);
        end
      end
      OP_ADD: begin
        for (int n = 0; n < 3; n++) begin
          p = rq.u[n];
          p = p + rq.v[n];
          w[n] = clip32(p, sat);
        end
      end
      OP_DOT: begin
        d = dot_of(rq.u, rq.v);
        r.is_scalar = 1'b1;
        if (d > 128'sh7fffffffffffffff) begin
          sat = 1'b1;
          r.res_scalar = 64'h7fffffffffffffff;
        end else if (d < -128'sh8000000000000000) begin
          sat = 1'b1;
          r.res_scalar = 64'h8000000000000000;
        end else begin
          r.res_scalar = d[63:0];
        end
      end
      OP_CROSS: cross_of(rq.u, rq.v, w, sat);
      OP_PROJ: begin
        nn = sum_squares(rq.v);
        if (nn == 0) begin
          r.zero_divisor = 1'b1;
        end else begin
          d  = dot_of(rq.u, rq.v);
          dm = (d < 0) ? 128'(-d) : 128'(d);
          for (int n = 0; n < 3; n++) begin
            av  = (rq.v[n] < 0) ? 64'(-64'sd1 * rq.v[n]) : 64'(rq.v[n]);
            q   = ({64'd0, av} * dm) / {64'd0, nn};
            neg = (d < 0) != (rq.v[n] < 0);
            if (q > (neg ? 128'h80000000 : 128'h7fffffff)) begin
              sat  = 1'b1;
              w[n] = neg ? 32'sh80000000 : 32'sh7fffffff;
            end else begin
              w[n] = neg ? -q[31:0] : q[31:0];
            end
          end
        end
      end
      OP_AREA: begin
        cross_of(rq.u, rq.v, w, sat);
        r.res_scalar = length_of(w);
        r.is_scalar  = 1'b1;
        w = '{default: '0};
      end
      default: ;  // unused code: all zero
    endcase
    r.res_x     = w[0];
    r.res_y     = w[1];
    r.res_z     = w[2];
    r.saturated = sat;
    return r;
  endfunction

  // ----------------------------------------------------------------- reporting
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // ----------------------------------------------------------------- stimulus
  function automatic logic signed [31:0] pick_component();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3, 4, 5: return 32'(signed'(20'($urandom)));  // small, either sign
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(input logic [2:0] k, input logic signed [31:0] a0,
                          input logic signed [31:0] a1, input logic signed [31:0] a2,
                          input logic signed [31:0] b0, input logic signed [31:0] b1,
                          input logic signed [31:0] b2, input logic signed [15:0] f);
    vec_req_t rq;
    rq.kind = k;
    rq.u = '{a0, a1, a2};
    rq.v = '{b0, b1, b2};
    rq.sf = f;
    pending_reqs.push_back(rq);
  endtask

  localparam logic signed [31:0] PMAX = 32'sh7fffffff;
  localparam logic signed [31:0] NMAX = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;

  initial begin
    vec_req_t rq;
    logic [2:0] k;
    // directed: extremes and the corner behaviors of each operation
    push_req(OP_MAG,   NMAX, NMAX, NMAX, 0, 0, 0, 0);
    push_req(OP_MAG,   PMAX, 0, ONE, 0, 0, 0, 0);
    push_req(OP_MAG,   0, 0, 0, 0, 0, 0, 0);
    push_req(OP_SCALE, PMAX, NMAX, ONE, 0, 0, 0, 16'sh7fff);
    push_req(OP_SCALE, NMAX, ONE, -ONE, 0, 0, 0, 16'sh8000);
    push_req(OP_SCALE, ONE, -ONE, 3, 0, 0, 0, 16'sh0001);
    push_req(OP_ADD,   PMAX, NMAX, ONE, PMAX, NMAX, -ONE, 0);
    push_req(OP_ADD,   PMAX, NMAX, 5, NMAX, PMAX, 7, 0);
    push_req(OP_DOT,   NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, 0);
    push_req(OP_DOT,   NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, 0);
    push_req(OP_DOT,   ONE, 2 * ONE, -ONE, ONE, ONE, ONE, 0);
    push_req(OP_CROSS, NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, 0);
    push_req(OP_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
    push_req(OP_CROSS, -1, 1, 0, 1, 1, 0, 0);  // floors a tiny negative
    push_req(OP_PROJ,  ONE, ONE, ONE, 0, 0, 0, 0);  // zero target
    push_req(OP_PROJ,  PMAX, PMAX, PMAX, 1, 0, 0, 0);
    push_req(OP_PROJ,  NMAX, NMAX, NMAX, -1, 0, 0, 0);
    push_req(OP_PROJ,  3, -7, 5, ONE, -ONE, 2 * ONE, 0);
    push_req(OP_AREA,  NMAX, PMAX, NMAX, PMAX, NMAX, PMAX, 0);
    push_req(OP_AREA,  ONE, 0, 0, 0, ONE, 0, 0);
    push_req(3'd7,     PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 16'sh7fff);
    push_req(3'd7,     NMAX, NMAX, NMAX, NMAX, NMAX, NMAX, 16'sh8000);
    // random: mostly valid codes, occasionally the unused one
    for (int i = 0; i < N_RANDOM; i++) begin
      k = ($urandom_range(0, 29) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
      rq.kind = k;
      for (int n = 0; n < 3; n++) begin
        rq.u[n] = pick_component();
        rq.v[n] = ($urandom_range(0, 19) == 0) ? 32'sd0 : pick_component();
      end
      if (k == OP_PROJ && $urandom_range(0, 9) == 0) rq.v = '{default: '0};
      rq.sf = 16'($urandom);
      pending_reqs.push_back(rq);
    end
    stim_done = 1'b1;
  end

  // ------------------------------------------------------------------- driver
  int src_idle;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.kind         <= '0;
      in_ch.u_x          <= '0;
      in_ch.u_y          <= '0;
      in_ch.u_z          <= '0;
      in_ch.v_x          <= '0;
      in_ch.v_y          <= '0;
      in_ch.v_z          <= '0;
      in_ch.scale_factor <= '0;
      src_idle           <= 0;
    end else begin
      // request taken at this edge: predict it and retire it from the queue
      if (in_ch.valid && in_ch.ready) begin
        expected_rsps.push_back(predict_vec_op(pending_reqs.pop_front()));
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (src_idle > 0) begin
          src_idle    <= src_idle - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
          src_idle    <= $urandom_range(0, 10);
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_ch.valid        <= 1'b1;
          in_ch.kind         <= pending_reqs[0].kind;
          in_ch.u_x          <= pending_reqs[0].u[0];
          in_ch.u_y          <= pending_reqs[0].u[1];
          in_ch.u_z          <= pending_reqs[0].u[2];
          in_ch.v_x          <= pending_reqs[0].v[0];
          in_ch.v_y          <= pending_reqs[0].v[1];
          in_ch.v_z          <= pending_reqs[0].v[2];
          in_ch.scale_factor <= pending_reqs[0].sf;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- result side
  int  sink_idle;
  int  hold_cnt;
  bit  hold_done;
  rsp_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_idle    <= 0;
      hold_cnt     <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd0);
        end else begin
          want = expected_rsps.pop_front();
          if (out_ch.res_x !== want.res_x)
            report_mismatch("res_x", 64'(out_ch.res_x), 64'(want.res_x));
          if (out_ch.res_y !== want.res_y)
            report_mismatch("res_y", 64'(out_ch.res_y), 64'(want.res_y));
          if (out_ch.res_z !== want.res_z)
            report_mismatch("res_z", 64'(out_ch.res_z), 64'(want.res_z));
          if (out_ch.res_scalar !== want.res_scalar)
            report_mismatch("res_scalar", out_ch.res_scalar, want.res_scalar);
          if (out_ch.is_scalar !== want.is_scalar)
            report_mismatch("is_scalar", 64'(out_ch.is_scalar), 64'(want.is_scalar));
          if (out_ch.saturated !== want.saturated)
            report_mismatch("saturated", 64'(out_ch.saturated), 64'(want.saturated));
          if (out_ch.zero_divisor !== want.zero_divisor)
            report_mismatch("zero_divisor", 64'(out_ch.zero_divisor),
                            64'(want.zero_divisor));
        end
      end
      // one long hold-off so the pipe backs up into the request side
      if (hold_cnt > 0) begin
        hold_cnt     <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
        if (hold_cnt == 1) hold_done <= 1'b1;
      end else if (!hold_done && n_results >= 300) begin
        hold_cnt     <= HOLD_LEN;
        out_ch.ready <= 1'b0;
      end else if (sink_idle > 0) begin
        sink_idle    <= sink_idle - 1;
        out_ch.ready <= 1'b0;
      end else if (pending_reqs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        sink_idle    <= $urandom_range(0, 10);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------- run control
  initial begin
    n_errors  = 0;
    n_results = 0;
    rst_n     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    repeat (120) @(posedge clk);  // a bit beyond the pipe depth
    if (n_errors == 0 && !out_ch.valid) begin
      $display("Test completed successfully");
    end else begin
      if (out_ch.valid) $display("[%0t] stray result after drain", $realtime);
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/v3a_pkg.sv
hdl/v3a_in_if.sv
hdl/v3a_out_if.sv
hdl/v3a_lane.sv
hdl/v3a_sqrt.sv
hdl/vector3_arith_unit.sv
hdl/v3a_checker.sv
verif/tb_vector3_arith_unit.sv
